// ===== rtl/sts_pkg.sv =====
// Shared types and constants for the sphere triangle subdivider.
package sts_pkg;
    localparam int unsigned CoordW = 16;
    localparam int unsigned SumW   = 17;
    localparam int unsigned SqW    = 36;
    localparam int unsigned RootW  = 18;
    localparam int unsigned NumW   = 31;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec c;
    } t_tri;

    typedef struct packed {
        t_tri       vtx;
        logic [1:0] passes;
    } t_job;
endpackage

// ===== rtl/sts_front.sv =====
// Input stage: captures a request with the pass count and queues it.
module sts_front #(
    parameter int unsigned MAX_PASSES = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sts_pkg::t_tri i_tri,
    input  logic [1:0]    i_passes,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output sts_pkg::t_job o_job
);
    import sts_pkg::*;

    localparam int unsigned Depth = 2;

    t_job       r_q [Depth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_passes;

    always_comb begin
        n_passes = (32'(i_passes) > MAX_PASSES) ? 2'(MAX_PASSES) : i_passes;
    end

    assign o_ready     = (r_cnt != 2'(Depth));
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_q[r_wp] <= '{vtx: i_tri, passes: n_passes};
                r_wp      <= ~r_wp;
            end
            if (o_job_valid && i_job_ready) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_job_valid && i_job_ready);
        end
    end
endmodule

// ===== rtl/sts_norm.sv =====
// Iterative midpoint normalizer: square root then three restoring divides, skipped when the root is zero.
module sts_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sts_pkg::t_vec i_p,
    input  sts_pkg::t_vec i_r,
    output logic          o_done,
    output sts_pkg::t_vec o_m
);
    import sts_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_DIVSET, S_DIV, S_FIN} t_state;

    t_state                   r_state;
    logic signed [SumW-1:0]   r_s [3];
    logic [SqW-1:0]           r_q;
    logic [SqW-1:0]           r_rem;
    logic [RootW-1:0]         r_root;
    logic [4:0]               r_cnt;
    logic [1:0]               r_comp;
    logic [NumW-1:0]          r_num;
    logic [NumW:0]            r_dr;
    logic [NumW-1:0]          r_quo;
    t_vec                     r_m;
    logic                     r_done;

    logic [SumW-1:0]   mag;
    logic [SqW+1:0]    trial;
    logic [SqW-1:0]    rem_sh;
    logic [NumW:0]     dr_sh;
    logic [NumW:0]     dvs;
    logic [NumW-1:0]   qabs;
    logic signed [CoordW-1:0] qsat;

    always_comb begin
        mag    = r_s[r_comp][SumW-1] ? SumW'(-r_s[r_comp]) : SumW'(r_s[r_comp]);
        rem_sh = {r_rem[SqW-3:0], r_q[SqW-1:SqW-2]};
        trial  = {2'b0, rem_sh} - {2'b0, (SqW-RootW-2)'(0), r_root, 2'b01};
        dvs    = (NumW+1)'(r_root);
        dr_sh  = {r_dr[NumW-1:0], r_num[NumW-1]};
        qabs   = (r_quo > NumW'(32767)) ? NumW'(32767) : r_quo;
        qsat   = r_s[r_comp][SumW-1] ? -$signed(qabs[CoordW-1:0]) : $signed(qabs[CoordW-1:0]);
    end

    assign o_done = r_done;
    assign o_m    = r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_s[0]  <= SumW'(i_p.x) + SumW'(i_r.x);
                        r_s[1]  <= SumW'(i_p.y) + SumW'(i_r.y);
                        r_s[2]  <= SumW'(i_p.z) + SumW'(i_r.z);
                        r_comp  <= 2'd0;
                        r_q     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_q    <= r_q + SqW'($unsigned(34'(mag) * 34'(mag)));
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 5'd0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_q <= {r_q[SqW-3:0], 2'b00};
                    if (!trial[SqW+1]) begin
                        r_rem  <= trial[SqW-1:0];
                        r_root <= {r_root[RootW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[RootW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(RootW-1)) begin
                        r_comp  <= 2'd0;
                        r_state <= S_DIVSET;
                    end
                end
                S_DIVSET: begin
                    if (r_root == '0) begin
                        r_m     <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_num   <= NumW'({mag, 14'b0}) + NumW'(r_root >> 1);
                        r_dr    <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 5'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[NumW-2:0], 1'b0};
                    if (dr_sh >= dvs) begin
                        r_dr  <= dr_sh - dvs;
                        r_quo <= {r_quo[NumW-2:0], 1'b1};
                    end else begin
                        r_dr  <= dr_sh;
                        r_quo <= {r_quo[NumW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(NumW-1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    case (r_comp)
                        2'd0:    r_m.x <= qsat;
                        2'd1:    r_m.y <= qsat;
                        default: r_m.z <= qsat;
                    endcase
                    if (r_comp == 2'd2) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_DIVSET;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/sts_back.sv =====
// Subdivision engine: triangle stack, midpoint sequencing and leaf output.
module sts_back #(
    parameter int unsigned MAX_PASSES = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  sts_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output sts_pkg::t_tri o_tri,
    output logic          o_last
);
    import sts_pkg::*;

    localparam int unsigned Depth = 3 * MAX_PASSES + 1;
    localparam int unsigned SpW   = $clog2(Depth + 1);
    localparam int unsigned IdxW  = $clog2(Depth);

    typedef enum logic [2:0] {S_IDLE, S_POP, S_READ, S_MID, S_WAIT, S_PUSH, S_OUT} t_state;

    t_state          r_state;
    t_tri            r_mem [Depth];
    logic [1:0]      r_lvl [Depth];
    logic [SpW-1:0]  r_sp;
    t_tri            r_rd;
    logic [1:0]      r_rd_lvl;
    t_tri            r_cur;
    logic [1:0]      r_cur_lvl;
    t_vec            r_mid [3];
    logic [1:0]      r_mi;
    logic [1:0]      r_pi;
    logic            r_start;
    logic            r_valid;
    t_tri            r_out;
    logic            r_last;

    t_vec  np, nr, nm;
    logic  nd;
    t_tri  push_tri;

    always_comb begin
        unique case (r_mi)
            2'd0:    begin np = r_cur.a; nr = r_cur.b; end
            2'd1:    begin np = r_cur.b; nr = r_cur.c; end
            default: begin np = r_cur.c; nr = r_cur.a; end
        endcase
        case (r_pi)
            2'd0:    push_tri = '{a: r_mid[0], b: r_mid[1], c: r_mid[2]};
            2'd1:    push_tri = '{a: r_cur.c, b: r_mid[2], c: r_mid[1]};
            2'd2:    push_tri = '{a: r_cur.b, b: r_mid[1], c: r_mid[0]};
            default: push_tri = '{a: r_cur.a, b: r_mid[0], c: r_mid[2]};
        endcase
    end

    sts_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_p     (np),
        .i_r     (nr),
        .o_done  (nd),
        .o_m     (nm)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_tri       = r_out;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_mem[0] <= i_job.vtx;
            r_lvl[0] <= i_job.passes;
        end else if (r_state == S_PUSH) begin
            r_mem[IdxW'(r_sp)] <= push_tri;
            r_lvl[IdxW'(r_sp)] <= r_cur_lvl - 2'd1;
        end
        r_rd     <= r_mem[IdxW'(r_sp - SpW'(1))];
        r_rd_lvl <= r_lvl[IdxW'(r_sp - SpW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_valid <= 1'b0;
            r_start <= 1'b0;
        end else begin
            if (r_valid && i_ready && r_state != S_OUT) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_sp    <= SpW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_cur     <= r_rd;
                    r_cur_lvl <= r_rd_lvl;
                    r_sp      <= r_sp - SpW'(1);
                    if (r_rd_lvl == 2'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_mi    <= 2'd0;
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_start <= 1'b0;
                    if (nd) begin
                        r_mid[r_mi] <= nm;
                        if (r_mi == 2'd2) begin
                            r_pi    <= 2'd0;
                            r_state <= S_PUSH;
                        end else begin
                            r_mi    <= r_mi + 2'd1;
                            r_state <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_PUSH: begin
                    r_sp <= r_sp + SpW'(1);
                    r_pi <= r_pi + 2'd1;
                    if (r_pi == 2'd3) begin
                        r_state <= S_POP;
                    end
                end
                S_OUT: begin
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        r_out   <= r_cur;
                        r_last  <= (r_sp == '0);
                        r_state <= (r_sp == '0) ? S_IDLE : S_POP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/sphere_triangle_subdivider.sv =====
// Top level of the sphere triangle subdivider.
//  channel  | handshake            | payload
//  input    | i_valid / o_ready    | i_a_x .. i_c_z
//  output   | o_valid / i_ready    | o_out_a_x .. o_out_c_z, o_last_leaf
//  config   | i_cfg_we             | i_cfg_data (subdivision passes)
// A request yields 4^passes leaves; a leaf pop runs through S_POP, S_READ and S_OUT,
// and S_OUT waits while the output is stalled. Each split runs three normalizations
// in the shared normalizer (sum of squares, square root, per-component divides),
// then pushes four sub-triangles onto the stack.
// Reset is synchronous, active low; passes reset to 0.
// A stalled output holds the back end; the two-entry queue takes requests until it is full.
module sphere_triangle_subdivider #(
    parameter int unsigned MAX_PASSES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_c_x,
    input  logic signed [15:0] i_c_y,
    input  logic signed [15:0] i_c_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_out_a_x,
    output logic signed [15:0] o_out_a_y,
    output logic signed [15:0] o_out_a_z,
    output logic signed [15:0] o_out_b_x,
    output logic signed [15:0] o_out_b_y,
    output logic signed [15:0] o_out_b_z,
    output logic signed [15:0] o_out_c_x,
    output logic signed [15:0] o_out_c_y,
    output logic signed [15:0] o_out_c_z,
    output logic               o_last_leaf
);
    import sts_pkg::*;

    logic [1:0] r_passes;
    t_tri       in_tri, out_tri;
    t_job       job;
    logic       job_valid, job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passes <= 2'd0;
        end else if (i_cfg_we) begin
            r_passes <= i_cfg_data;
        end
    end

    assign in_tri = '{a: '{x: i_a_x, y: i_a_y, z: i_a_z},
                      b: '{x: i_b_x, y: i_b_y, z: i_b_z},
                      c: '{x: i_c_x, y: i_c_y, z: i_c_z}};

    sts_front #(.MAX_PASSES(MAX_PASSES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_tri       (in_tri),
        .i_passes    (r_passes),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    sts_back #(.MAX_PASSES(MAX_PASSES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tri       (out_tri),
        .o_last      (o_last_leaf)
    );

    assign o_out_a_x = out_tri.a.x;
    assign o_out_a_y = out_tri.a.y;
    assign o_out_a_z = out_tri.a.z;
    assign o_out_b_x = out_tri.b.x;
    assign o_out_b_y = out_tri.b.y;
    assign o_out_b_z = out_tri.b.z;
    assign o_out_c_x = out_tri.c.x;
    assign o_out_c_y = out_tri.c.y;
    assign o_out_c_z = out_tri.c.z;
endmodule
